FILE: hw/rtl/mbrtu_pkg.sv
// mbrtu_pkg: shared types, codes and the crc-16 byte step for the modbus rtu responder
// depends on nothing; imported by every module of the block
package mbrtu_pkg;

	// register map size and response limits
	localparam int MAP_REGS_DEF   = 6;
	localparam int READ_WORDS_MAX = 6;

	// modbus function codes
	localparam logic [7:0] FUNC_READ  = 8'h03;
	localparam logic [7:0] FUNC_WRITE = 8'h06;

	// crc-16 (reflected polynomial)
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// configuration register indexes and reset values
	localparam logic CFG_SLAVE_ADDRESS    = 1'b0;
	localparam logic CFG_SETPOINT_INITIAL = 1'b1;
	localparam logic [7:0] SLAVE_ADDR_RST = 8'h01;
	localparam logic [7:0] SETPOINT_RST   = 8'h00;

	// request clamps
	localparam logic [1:0] SPEED_MAX = 2'd3;
	localparam logic       VALVE_MAX = 1'b1;

	// map register numbers with side effects on write
	localparam logic [7:0] REG_SPEED    = 8'd0;
	localparam logic [7:0] REG_VALVE    = 8'd1;
	localparam logic [7:0] REG_SETPOINT = 8'd2;

	// one checked request handed from the parser to the responder
	typedef struct packed {
		logic        is_read;
		logic [7:0]  addr;
		logic [7:0]  regnum;
		logic [7:0]  b4;
		logic [7:0]  b5;
		logic [7:0]  crc_lo;
		logic [7:0]  crc_hi;
		logic [1:0]  speed;
		logic        valve;
		logic [7:0]  setpoint;
		logic [15:0] sensor_one;
		logic [15:0] sensor_two;
		logic [15:0] sensor_three;
	} cmd_t;

	typedef enum logic {
		BK_IDLE,
		BK_SEND
	} back_state_t;

	// fold one byte into a modbus crc
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

FILE: hw/rtl/mbrtu_front.sv
// mbrtu_front: request parser, checks each received byte and the frame crc
// depends on mbrtu_pkg; emits one cmd_t per good frame
module mbrtu_front import mbrtu_pkg::*; #(
	parameter int MAP_REGISTERS = MAP_REGS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic [7:0]  rx_byte,
	input  logic [1:0]  speed_now,
	input  logic        valve_now,
	input  logic [7:0]  setpoint_now,
	input  logic [15:0] sensor_one_word,
	input  logic [15:0] sensor_two_word,
	input  logic [15:0] sensor_three_word,
	input  logic [7:0]  slave_address,
	output logic        cmd_push,
	output cmd_t        cmd
);

	localparam logic [8:0] MAP_LIM  = 9'(MAP_REGISTERS);
	localparam logic [8:0] READ_LIM = 9'(READ_WORDS_MAX);

	logic [2:0]  pos_q;
	logic [15:0] crc_q;
	logic [7:0]  addr_q;
	logic [7:0]  func_q;
	logic [7:0]  reg_q;
	logic [7:0]  b4_q;
	logic [7:0]  b5_q;
	logic [7:0]  b6_q;
	logic        ok;
	logic        is_write;
	logic [8:0]  reg_end;

	assign is_write = (func_q == FUNC_WRITE);
	assign reg_end  = {1'b0, reg_q} + {1'b0, rx_byte};

	// per-position byte check
	always_comb begin
		case (pos_q)
			3'd0:    ok = (rx_byte == slave_address);
			3'd1:    ok = (rx_byte == FUNC_READ) || (rx_byte == FUNC_WRITE);
			3'd2:    ok = (rx_byte == 8'h00);
			3'd3:    ok = ({1'b0, rx_byte} < MAP_LIM);
			3'd4:    ok = is_write || (rx_byte == 8'h00);
			3'd5:    ok = is_write || ((reg_end <= MAP_LIM) && ({1'b0, rx_byte} <= READ_LIM));
			3'd6:    ok = 1'b1;
			3'd7:    ok = (b6_q == crc_q[7:0]) && (rx_byte == crc_q[15:8]);
			default: ok = 1'b0;
		endcase
	end

	// command toward the responder, map sampled with the last crc byte
	assign cmd_push = take && (pos_q == 3'd7) && ok;
	always_comb begin
		cmd.is_read      = (func_q == FUNC_READ);
		cmd.addr         = addr_q;
		cmd.regnum       = reg_q;
		cmd.b4           = b4_q;
		cmd.b5           = b5_q;
		cmd.crc_lo       = b6_q;
		cmd.crc_hi       = rx_byte;
		cmd.speed        = speed_now;
		cmd.valve        = valve_now;
		cmd.setpoint     = setpoint_now;
		cmd.sensor_one   = sensor_one_word;
		cmd.sensor_two   = sensor_two_word;
		cmd.sensor_three = sensor_three_word;
	end

	// position and crc
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 3'd0;
			crc_q <= CRC_INIT;
		end else if (take) begin
			if (!ok || pos_q == 3'd7) begin
				pos_q <= 3'd0;
				crc_q <= CRC_INIT;
			end else begin
				pos_q <= pos_q + 3'd1;
				if (pos_q != 3'd6) begin
					crc_q <= crc_feed(crc_q, rx_byte);
				end
			end
		end
	end

	// frame bytes
	always_ff @(posedge clk) begin
		if (take) begin
			case (pos_q)
				3'd0:    addr_q <= rx_byte;
				3'd1:    func_q <= rx_byte;
				3'd3:    reg_q  <= rx_byte;
				3'd4:    b4_q   <= rx_byte;
				3'd5:    b5_q   <= rx_byte;
				3'd6:    b6_q   <= rx_byte;
				default: ;
			endcase
		end
	end

endmodule

FILE: hw/rtl/mbrtu_cmdq.sv
// mbrtu_cmdq: two-entry queue of checked requests between parser and responder
// depends on mbrtu_pkg for cmd_t
module mbrtu_cmdq import mbrtu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t din,
	output logic full,
	input  logic pop,
	output cmd_t dout,
	output logic empty
);

	cmd_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign dout  = mem_q[rd_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

FILE: hw/rtl/mbrtu_back.sv
// mbrtu_back: responder, updates requests and sends the response one byte per cycle
// while out_pop keeps up; depends on mbrtu_pkg; owns the request registers and the output register
module mbrtu_back import mbrtu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  cmd_t       cmd,
	output logic       cmd_pop,
	input  logic       setpoint_load,
	input  logic [7:0] setpoint_value,
	input  logic       out_pop,
	output logic       out_valid,
	output logic [7:0] tx_byte,
	output logic       last_byte,
	output logic [1:0] speed_request,
	output logic       valve_request,
	output logic [7:0] setpoint_request
);

	back_state_t state_q, state_d;
	cmd_t        cur_q;
	logic [4:0]  k_q;
	logic [15:0] crc_q;
	logic [1:0]  speed_q;
	logic        valve_q;
	logic [7:0]  setp_q;
	logic        out_valid_q;
	logic [7:0]  tx_q;
	logic        last_q;
	logic [1:0]  speed_out_q;
	logic        valve_out_q;
	logic [7:0]  setp_out_q;

	logic        load;
	logic [7:0]  byte_d;
	logic        last_d;
	logic        feed_d;
	logic [4:0]  len;
	logic [4:0]  off;
	logic [4:0]  r;
	logic [15:0] word;

	// response length and map word under the cursor
	assign len  = 5'd5 + {1'b0, cur_q.b5[2:0], 1'b0};
	assign off  = k_q - 5'd3;
	assign r    = cur_q.regnum[4:0] + {1'b0, off[4:1]};

	always_comb begin
		case (r)
			5'd0:    word = {14'h0000, cur_q.speed};
			5'd1:    word = {15'h0000, cur_q.valve};
			5'd2:    word = {8'h00, cur_q.setpoint};
			5'd3:    word = cur_q.sensor_one;
			5'd4:    word = cur_q.sensor_two;
			5'd5:    word = cur_q.sensor_three;
			default: word = 16'h0000;
		endcase
	end

	// next response byte
	always_comb begin
		byte_d = 8'h00;
		last_d = 1'b0;
		feed_d = 1'b0;
		if (cur_q.is_read) begin
			last_d = (k_q == len - 5'd1);
			feed_d = (k_q < len - 5'd2);
			if (k_q == 5'd0) begin
				byte_d = cur_q.addr;
			end else if (k_q == 5'd1) begin
				byte_d = FUNC_READ;
			end else if (k_q == 5'd2) begin
				byte_d = {cur_q.b5[6:0], 1'b0};
			end else if (k_q == len - 5'd2) begin
				byte_d = crc_q[7:0];
			end else if (k_q == len - 5'd1) begin
				byte_d = crc_q[15:8];
			end else if (!off[0]) begin
				byte_d = word[15:8];
			end else begin
				byte_d = word[7:0];
			end
		end else begin
			last_d = (k_q == 5'd7);
			case (k_q[2:0])
				3'd0:    byte_d = cur_q.addr;
				3'd1:    byte_d = FUNC_WRITE;
				3'd2:    byte_d = 8'h00;
				3'd3:    byte_d = cur_q.regnum;
				3'd4:    byte_d = cur_q.b4;
				3'd5:    byte_d = cur_q.b5;
				3'd6:    byte_d = cur_q.crc_lo;
				3'd7:    byte_d = cur_q.crc_hi;
				default: byte_d = 8'h00;
			endcase
		end
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		cmd_pop = 1'b0;
		load    = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					state_d = BK_SEND;
				end
			end
			BK_SEND: begin
				load = !out_valid_q || out_pop;
				if (load && last_d) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// control state and request registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
			speed_q     <= 2'd0;
			valve_q     <= 1'b0;
			setp_q      <= SETPOINT_RST;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_pop) begin
				out_valid_q <= 1'b0;
			end
			if (setpoint_load) begin
				setp_q <= setpoint_value;
			end else if (cmd_pop && !cmd.is_read) begin
				if (cmd.regnum == REG_SPEED) begin
					speed_q <= ({cmd.b4, cmd.b5} < 16'd4) ? cmd.b5[1:0] : SPEED_MAX;
				end else if (cmd.regnum == REG_VALVE) begin
					valve_q <= ({cmd.b4, cmd.b5} < 16'd2) ? cmd.b5[0] : VALVE_MAX;
				end else if (cmd.regnum == REG_SETPOINT) begin
					setp_q <= cmd.b5;
				end
			end
		end
	end

	// current command, cursor, response crc and output register
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q <= cmd;
			k_q   <= 5'd0;
			crc_q <= CRC_INIT;
		end else if (load) begin
			k_q <= k_q + 5'd1;
			if (feed_d) begin
				crc_q <= crc_feed(crc_q, byte_d);
			end
		end
		if (load) begin
			tx_q        <= byte_d;
			last_q      <= last_d;
			speed_out_q <= speed_q;
			valve_out_q <= valve_q;
			setp_out_q  <= setp_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign tx_byte          = tx_q;
	assign last_byte        = last_q;
	assign speed_request    = speed_out_q;
	assign valve_request    = valve_out_q;
	assign setpoint_request = setp_out_q;

endmodule

FILE: hw/rtl/modbus_rtu_slave_frame_responder.sv
// modbus_rtu_slave_frame_responder: top level, config registers, parser, queue and responder
// depends on mbrtu_pkg, mbrtu_front, mbrtu_cmdq, mbrtu_back
//
// channel   direction  handshake               payload
// rx        in         push / full             rx_byte, speed_now, valve_now, setpoint_now,
//                                              sensor_one_word, sensor_two_word, sensor_three_word
// tx        out        empty / pop             tx_byte, last_byte, speed_request,
//                                              valve_request, setpoint_request
// config    in         psel/penable/pwrite     paddr, pwdata, prdata, pready
//
// the parser takes one received byte per cycle while full is low, checking it in that cycle (crc on the last byte)
// a good frame enters a two-entry request queue; full rises while both entries wait
// the responder picks up a request in its idle state, then sends 8 bytes (write echo)
// or 5 + 2 * count bytes (read) at one per cycle, paced by pop on the output register
// reset clears the parser, queue, responder and requests; no clearing pass is needed
module modbus_rtu_slave_frame_responder import mbrtu_pkg::*; #(
	parameter int MAP_REGISTERS = MAP_REGS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	input  logic [1:0]  speed_now,
	input  logic        valve_now,
	input  logic [7:0]  setpoint_now,
	input  logic [15:0] sensor_one_word,
	input  logic [15:0] sensor_two_word,
	input  logic [15:0] sensor_three_word,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  tx_byte,
	output logic        last_byte,
	output logic [1:0]  speed_request,
	output logic        valve_request,
	output logic [7:0]  setpoint_request,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0] slave_addr_q;
	logic [7:0] setp_init_q;
	logic       cfg_wr;
	logic       take;
	logic       cmd_push;
	cmd_t       cmd_in;
	cmd_t       cmd_out;
	logic       cmdq_empty;
	logic       cmd_pop;
	logic       out_valid;

	// apb register file
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q <= SLAVE_ADDR_RST;
			setp_init_q  <= SETPOINT_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				CFG_SLAVE_ADDRESS:    slave_addr_q <= pwdata[7:0];
				CFG_SETPOINT_INITIAL: setp_init_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			CFG_SLAVE_ADDRESS:    prdata = {24'h000000, slave_addr_q};
			CFG_SETPOINT_INITIAL: prdata = {24'h000000, setp_init_q};
			default:              prdata = 32'h00000000;
		endcase
	end

	assign take  = push && !full;
	assign empty = !out_valid;

	mbrtu_front #(
		.MAP_REGISTERS(MAP_REGISTERS)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.take             (take),
		.rx_byte          (rx_byte),
		.speed_now        (speed_now),
		.valve_now        (valve_now),
		.setpoint_now     (setpoint_now),
		.sensor_one_word  (sensor_one_word),
		.sensor_two_word  (sensor_two_word),
		.sensor_three_word(sensor_three_word),
		.slave_address    (slave_addr_q),
		.cmd_push         (cmd_push),
		.cmd              (cmd_in)
	);

	mbrtu_cmdq u_cmdq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmd_push),
		.din   (cmd_in),
		.full  (full),
		.pop   (cmd_pop),
		.dout  (cmd_out),
		.empty (cmdq_empty)
	);

	mbrtu_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (!cmdq_empty),
		.cmd             (cmd_out),
		.cmd_pop         (cmd_pop),
		.setpoint_load   (cfg_wr && (paddr[2] == CFG_SETPOINT_INITIAL)),
		.setpoint_value  (pwdata[7:0]),
		.out_pop         (pop && out_valid),
		.out_valid       (out_valid),
		.tx_byte         (tx_byte),
		.last_byte       (last_byte),
		.speed_request   (speed_request),
		.valve_request   (valve_request),
		.setpoint_request(setpoint_request)
	);

endmodule
